// ===== hw/rtl/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// shared types and constants of the hsv to rgb converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

  typedef logic [14:0] hue_t;
  typedef logic [12:0] q12_t;
  typedef logic [11:0] frac_t;
  typedef logic [3:0]  sector_t;
  typedef logic [23:0] factor_t;
  typedef logic [24:0] sprod_t;
  typedef logic [7:0]  chan_t;

  // hue units per 60 degree sector (1/64 degree units)
  localparam frac_t   SECTOR_UNITS = 12'd3840;
  // highest sector a 15-bit hue can reach
  localparam int      MAX_SECTOR   = 8;
  // 1.0 in q12
  localparam q12_t    ONE_Q12      = 13'd4096;
  // 4096 * 3840, the full channel factor
  localparam factor_t FULL_K       = 24'd15728640;

  // sector codes, everything above magenta-red uses the last arm
  localparam sector_t SEC_RED_YEL  = 4'd0;
  localparam sector_t SEC_YEL_GRN  = 4'd1;
  localparam sector_t SEC_GRN_CYN  = 4'd2;
  localparam sector_t SEC_CYN_BLU  = 4'd3;
  localparam sector_t SEC_BLU_MAG  = 4'd4;

  // final divide by 15: floor(x / 15) = (x * 34953) >> 19 for x < 2^16
  localparam logic [15:0] RECIP15       = 16'd34953;
  localparam int          RECIP15_SHIFT = 19;
  // 256 * 15, quotients at or above this saturate
  localparam q12_t        CLAMP_LIMIT   = 13'd3840;
  localparam chan_t       CHAN_MAX      = 8'd255;

endpackage

`default_nettype wire

// ===== hw/rtl/hsv_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// pipelined hsv to 8-bit rgb pixel converter, when not stalled one pixel per clock
// ----------------------------------------------------------------------------
//
// channel   | dir | tdata fields (lsb first)                 | tuser/tlast
// ----------+-----+------------------------------------------+------------
// s_axis    | in  | hue[14:0] saturation[27:15] brightness[40:28] | none
// m_axis    | out | red[7:0] green[15:8] blue[23:16]          | none
//
// - six register stages, a request enters each clock while the pipe is not stalled
// - latency is set by the sector split, the two saturation products, the
//   factor select and the three stages of the channel scaler
// - rst clears the valid bits only, data registers carry no reset
// - the whole pipe moves together; it stalls only when the output holds a
//   result that the sink has not taken, so nothing is dropped or repeated
//
`default_nettype none

module hsv_to_rgb_converter_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // hue[14:0], saturation[27:15], brightness[40:28], zero pad[47:41]
  input  wire  [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [23:0] m_axis_tdata
);

  localparam int STAGES = 6;

  // pipe advance: output empty or being taken
  logic en;
  logic [STAGES-1:0] valid;

  assign en            = !valid[STAGES-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[STAGES-2:0], s_axis_tvalid};
    end
  end

  // input fields
  hsvrgb_pkg::hue_t in_hue;
  hsvrgb_pkg::q12_t in_sat;
  hsvrgb_pkg::q12_t in_val;

  assign in_hue = s_axis_tdata[14:0];
  assign in_sat = s_axis_tdata[27:15];
  assign in_val = s_axis_tdata[40:28];

  // stage 0: split hue into sector and fraction by parallel threshold compares
  hsvrgb_pkg::sector_t sec_next;
  hsvrgb_pkg::hue_t    base;
  hsvrgb_pkg::hue_t    rem_full;

  always_comb begin
    sec_next = hsvrgb_pkg::SEC_RED_YEL;
    base     = '0;
    for (int i = 1; i <= hsvrgb_pkg::MAX_SECTOR; i++) begin
      if (in_hue >= 15'(i * int'(hsvrgb_pkg::SECTOR_UNITS))) begin
        sec_next = 4'(i);
        base     = 15'(i * int'(hsvrgb_pkg::SECTOR_UNITS));
      end
    end
  end

  assign rem_full = in_hue - base;

  hsvrgb_pkg::sector_t s0_sec;
  hsvrgb_pkg::frac_t   s0_rem;
  hsvrgb_pkg::q12_t    s0_sat;
  hsvrgb_pkg::q12_t    s0_val;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sec <= sec_next;
      s0_rem <= rem_full[11:0];
      s0_sat <= in_sat;
      s0_val <= in_val;
    end
  end

  // stage 1: saturation products for q and t, p factor clamped at zero
  hsvrgb_pkg::frac_t   rem_inv;
  hsvrgb_pkg::factor_t kp_next;
  logic [24:0]         kp_wide;

  assign rem_inv = hsvrgb_pkg::SECTOR_UNITS - s0_rem;
  assign kp_wide = (hsvrgb_pkg::ONE_Q12 - s0_sat) * hsvrgb_pkg::SECTOR_UNITS;

  always_comb begin
    // saturation above 1.0 drives p negative, which clamps the channel to zero
    if (s0_sat < hsvrgb_pkg::ONE_Q12) begin
      kp_next = kp_wide[23:0];
    end else begin
      kp_next = '0;
    end
  end

  hsvrgb_pkg::sector_t s1_sec;
  hsvrgb_pkg::sprod_t  s1_prod_q;
  hsvrgb_pkg::sprod_t  s1_prod_t;
  hsvrgb_pkg::factor_t s1_kp;
  hsvrgb_pkg::q12_t    s1_val;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sec    <= s0_sec;
      s1_prod_q <= s0_sat * s0_rem;
      s1_prod_t <= s0_sat * rem_inv;
      s1_kp     <= kp_next;
      s1_val    <= s0_val;
    end
  end

  // stage 2: q and t factors clamped at zero, then the six-sector select
  hsvrgb_pkg::factor_t kq;
  hsvrgb_pkg::factor_t kt;
  hsvrgb_pkg::factor_t kr_next;
  hsvrgb_pkg::factor_t kg_next;
  hsvrgb_pkg::factor_t kb_next;
  hsvrgb_pkg::sprod_t  kq_wide;
  hsvrgb_pkg::sprod_t  kt_wide;

  assign kq_wide = {1'b0, hsvrgb_pkg::FULL_K} - s1_prod_q;
  assign kt_wide = {1'b0, hsvrgb_pkg::FULL_K} - s1_prod_t;

  always_comb begin
    kq = (s1_prod_q < {1'b0, hsvrgb_pkg::FULL_K}) ? kq_wide[23:0] : '0;
    kt = (s1_prod_t < {1'b0, hsvrgb_pkg::FULL_K}) ? kt_wide[23:0] : '0;
  end

  always_comb begin
    case (s1_sec)
      hsvrgb_pkg::SEC_RED_YEL: begin
        kr_next = hsvrgb_pkg::FULL_K; kg_next = kt; kb_next = s1_kp;
      end
      hsvrgb_pkg::SEC_YEL_GRN: begin
        kr_next = kq; kg_next = hsvrgb_pkg::FULL_K; kb_next = s1_kp;
      end
      hsvrgb_pkg::SEC_GRN_CYN: begin
        kr_next = s1_kp; kg_next = hsvrgb_pkg::FULL_K; kb_next = kt;
      end
      hsvrgb_pkg::SEC_CYN_BLU: begin
        kr_next = s1_kp; kg_next = kq; kb_next = hsvrgb_pkg::FULL_K;
      end
      hsvrgb_pkg::SEC_BLU_MAG: begin
        kr_next = kt; kg_next = s1_kp; kb_next = hsvrgb_pkg::FULL_K;
      end
      // magenta-red, and hues of 360 degrees or more
      default: begin
        kr_next = hsvrgb_pkg::FULL_K; kg_next = s1_kp; kb_next = kq;
      end
    endcase
  end

  hsvrgb_pkg::factor_t s2_kr;
  hsvrgb_pkg::factor_t s2_kg;
  hsvrgb_pkg::factor_t s2_kb;
  hsvrgb_pkg::q12_t    s2_val;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kr  <= kr_next;
      s2_kg  <= kg_next;
      s2_kb  <= kb_next;
      s2_val <= s1_val;
    end
  end

  // stages 3 to 5: one scaler per channel, last stage is the output register
  hsvrgb_pkg::chan_t red;
  hsvrgb_pkg::chan_t green;
  hsvrgb_pkg::chan_t blue;

  hsvrgb_scale u_scale_red (
    .clk  (clk),
    .en   (en),
    .v    (s2_val),
    .k    (s2_kr),
    .chan (red)
  );

  hsvrgb_scale u_scale_green (
    .clk  (clk),
    .en   (en),
    .v    (s2_val),
    .k    (s2_kg),
    .chan (green)
  );

  hsvrgb_scale u_scale_blue (
    .clk  (clk),
    .en   (en),
    .v    (s2_val),
    .k    (s2_kb),
    .chan (blue)
  );

  assign m_axis_tdata = {blue, green, red};

endmodule

`default_nettype wire

// ===== hw/rtl/hsvrgb_scale.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_scale
// three-stage channel scaler: byte = min(255, floor(v * k * 255 / (2^32 * 15)))
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_scale (
  input  wire                     clk,
  input  wire                     en,
  input  wire hsvrgb_pkg::q12_t   v,
  input  wire hsvrgb_pkg::factor_t k,
  output hsvrgb_pkg::chan_t       chan
);

  logic [36:0] prod;
  logic [12:0] quo;
  logic [44:0] num;
  logic [27:0] recip_prod;
  hsvrgb_pkg::chan_t chan_next;

  // times 255 as shift and subtract, then drop the 2^32 part of the divisor
  assign num = {prod, 8'd0} - {8'd0, prod};

  assign recip_prod = quo[11:0] * hsvrgb_pkg::RECIP15;

  always_comb begin
    if (quo >= hsvrgb_pkg::CLAMP_LIMIT) begin
      chan_next = hsvrgb_pkg::CHAN_MAX;
    end else begin
      chan_next = recip_prod[hsvrgb_pkg::RECIP15_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= v * k;
      quo  <= num[44:32];
      chan <= chan_next;
    end
  end

endmodule

`default_nettype wire

// ===== sim/hsv_to_rgb_converter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core_tb
// self-checking bench of the hsv to rgb pixel converter: an exact integer
// model predicts each pixel, results are matched in order field by field,
// with random bursty sending and a stalling sink on the output
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_core_tb;

  localparam longint HUE_PER_SECTOR = 3840;
  localparam longint Q12_UNITY      = 4096;
  localparam longint FULL_FACTOR    = Q12_UNITY * HUE_PER_SECTOR;
  localparam longint SCALE_DIVISOR  = Q12_UNITY * Q12_UNITY * HUE_PER_SECTOR;
  localparam int     CLK_HALF       = 4;
  localparam int     RESET_CYCLES   = 7;
  localparam int     RANDOM_PIXELS  = 1700;
  // pipe is six deep; the drain wait flushes anything stray
  localparam int     DRAIN_CYCLES   = 12;
  // longest quiet stretch in a good run is a sender gap plus a sink stall
  // plus the pipe depth
  localparam int     QUIET_LIMIT    = 4000;

  typedef struct packed {
    hsvrgb_pkg::chan_t red;
    hsvrgb_pkg::chan_t green;
    hsvrgb_pkg::chan_t blue;
  } rgb_pixel_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  rgb_pixel_t rgb_expected_q[$];
  int         mismatch_count;
  int         quiet_cycles;
  int         burst_left;

  hsv_to_rgb_converter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // pixel model
  // ---------------------------------------------------------------------------

  // 255 * v * k / (4096 * 4096 * 3840), clamped to a byte, truncated
  function automatic hsvrgb_pkg::chan_t scale_channel(input longint bright,
                                                      input longint factor);
    longint product;
    longint quotient;
    product = bright * factor * 255;
    if (product <= 0) begin
      return '0;
    end
    quotient = product / SCALE_DIVISOR;
    if (quotient > 255) begin
      quotient = 255;
    end
    return hsvrgb_pkg::chan_t'(quotient);
  endfunction

  function automatic rgb_pixel_t predict_rgb(input hsvrgb_pkg::hue_t hue,
                                             input hsvrgb_pkg::q12_t sat,
                                             input hsvrgb_pkg::q12_t bright);
    longint              h;
    longint              s;
    longint              v;
    longint              frac;
    longint              kv;
    longint              kp;
    longint              kq;
    longint              kt;
    longint              kr;
    longint              kg;
    longint              kb;
    hsvrgb_pkg::sector_t sector;
    rgb_pixel_t          pix;
    h      = longint'(hue);
    s      = longint'(sat);
    v      = longint'(bright);
    sector = hsvrgb_pkg::sector_t'(h / HUE_PER_SECTOR);
    frac   = h % HUE_PER_SECTOR;
    kv     = FULL_FACTOR;
    kp     = HUE_PER_SECTOR * (Q12_UNITY - s);
    kq     = FULL_FACTOR - s * frac;
    kt     = FULL_FACTOR - s * (HUE_PER_SECTOR - frac);
    case (sector)
      hsvrgb_pkg::SEC_RED_YEL: begin kr = kv; kg = kt; kb = kp; end
      hsvrgb_pkg::SEC_YEL_GRN: begin kr = kq; kg = kv; kb = kp; end
      hsvrgb_pkg::SEC_GRN_CYN: begin kr = kp; kg = kv; kb = kt; end
      hsvrgb_pkg::SEC_CYN_BLU: begin kr = kp; kg = kq; kb = kv; end
      hsvrgb_pkg::SEC_BLU_MAG: begin kr = kt; kg = kp; kb = kv; end
      // magenta-red and every wrap past 360 degrees
      default:                 begin kr = kv; kg = kp; kb = kq; end
    endcase
    pix.red   = scale_channel(v, kr);
    pix.green = scale_channel(v, kg);
    pix.blue  = scale_channel(v, kb);
    return pix;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: requests push a prediction, results pop and compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_pixel_t want;
    rgb_pixel_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rgb_expected_q.push_back(predict_rgb(s_axis_tdata[14:0], s_axis_tdata[27:15],
                                             s_axis_tdata[40:28]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = rgb_pixel_t'({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]});
        if (rgb_expected_q.size() == 0) begin
          $error("unexpected result: red %0d green %0d blue %0d",
                 got.red, got.green, got.blue);
          mismatch_count++;
        end else begin
          want = rgb_expected_q.pop_front();
          if (got.red !== want.red) begin
            $error("red mismatch: expected %0d, got %0d", want.red, got.red);
            mismatch_count++;
          end
          if (got.green !== want.green) begin
            $error("green mismatch: expected %0d, got %0d", want.green, got.green);
            mismatch_count++;
          end
          if (got.blue !== want.blue) begin
            $error("blue mismatch: expected %0d, got %0d", want.blue, got.blue);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles where neither side moves anything
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sink: stall runs of random length, with long smooth stretches between
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int smooth_left;
    stall_left    = 0;
    smooth_left   = 200;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (smooth_left > 0) begin
        smooth_left--;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        case ($urandom_range(0, 63))
          0:       smooth_left = $urandom_range(50, 300);
          1, 2:    stall_left  = $urandom_range(1, 12);
          3, 4, 5: stall_left  = 1;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // one request; tvalid stays up within a burst and drops only for a gap
  task automatic send_hsv_pixel(input hsvrgb_pkg::hue_t hue, input hsvrgb_pkg::q12_t sat,
                                input hsvrgb_pkg::q12_t bright);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, bright, sat, hue};
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
  endtask

  function automatic hsvrgb_pkg::q12_t pick_q12();
    case ($urandom_range(0, 19))
      0:       return hsvrgb_pkg::q12_t'(0);
      1:       return hsvrgb_pkg::q12_t'(Q12_UNITY);
      2, 3:    return hsvrgb_pkg::q12_t'($urandom_range(4097, 8191));
      default: return hsvrgb_pkg::q12_t'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic hsvrgb_pkg::hue_t pick_hue();
    int edge_sector;
    if ($urandom_range(0, 9) == 0) begin
      // land on or just below a sector boundary
      edge_sector = $urandom_range(1, 8);
      return hsvrgb_pkg::hue_t'(edge_sector * HUE_PER_SECTOR - $urandom_range(0, 1));
    end
    return hsvrgb_pkg::hue_t'($urandom_range(0, 32767));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_field_extremes();
    send_hsv_pixel(15'd0, 13'd0, 13'd0);
    send_hsv_pixel(15'd32767, 13'd8191, 13'd8191);
    send_hsv_pixel(15'd0, 13'd4096, 13'd4096);
    send_hsv_pixel(15'd32767, 13'd0, 13'd4096);
  endtask

  // sector boundaries: first hue of sectors 1 to 8, last of sectors 0 and 5, three sectors past 360 degrees
  task automatic test_sector_edges();
    send_hsv_pixel(15'd3839, 13'd4096, 13'd4096);
    send_hsv_pixel(15'd3840, 13'd4096, 13'd4096);
    send_hsv_pixel(15'd7680, 13'd4096, 13'd4096);
    send_hsv_pixel(15'd11520, 13'd3000, 13'd4096);
    send_hsv_pixel(15'd15360, 13'd4096, 13'd4096);
    send_hsv_pixel(15'd19200, 13'd2048, 13'd4096);
    send_hsv_pixel(15'd23039, 13'd4096, 13'd4096);
    send_hsv_pixel(15'd23040, 13'd4096, 13'd4096);
    send_hsv_pixel(15'd26880, 13'd2500, 13'd4096);
    send_hsv_pixel(15'd30720, 13'd4096, 13'd4096);
  endtask

  // no saturation gives a gray of the scaled brightness
  task automatic test_gray();
    send_hsv_pixel(15'd1234, 13'd0, 13'd4096);
    send_hsv_pixel(15'd20000, 13'd0, 13'd2048);
    send_hsv_pixel(15'd5000, 13'd0, 13'd8191);
  endtask

  // saturation past 1.0 drives some factors negative, those channels clamp at zero
  task automatic test_oversaturation();
    send_hsv_pixel(15'd1000, 13'd8191, 13'd4096);
    send_hsv_pixel(15'd17000, 13'd6000, 13'd4096);
  endtask

  // brightness past 1.0 clips the full-factor channel at full scale
  task automatic test_overbright();
    send_hsv_pixel(15'd9000, 13'd2048, 13'd8191);
    send_hsv_pixel(15'd25000, 13'd4096, 13'd6000);
  endtask

  task automatic test_random_pixels();
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      send_hsv_pixel(pick_hue(), pick_q12(), pick_q12());
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    rst            = 1'b1;
    mismatch_count = 0;
    burst_left     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_sector_edges();
    test_gray();
    test_oversaturation();
    test_overbright();
    test_random_pixels();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (rgb_expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
